### sv/wshf_pkg.sv
package wshf_pkg;

  localparam int XW = 9;
  localparam int YW = 10;
  localparam int RW = 3;
  localparam int TOTW = 18;
  localparam int LAGW = 12;
  localparam int ACCW = 19;
  localparam int MidDepth = 4;
  localparam int OutDepth = 8;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH    = 2'd0,
    REG_GRID_HEIGHT   = 2'd1,
    REG_WINDOW_RADIUS = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic               action;
    logic               known;
    logic signed [15:0] level;
    logic [15:0]        prior_step;
  } item_t;

  typedef struct packed {
    logic [15:0] step_height;
    logic [7:0]  row;
    logic [7:0]  column;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic [XW-1:0] width;
    logic [XW-1:0] height;
    logic [RW-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic               known;
    logic signed [15:0] level;
    logic [15:0]        prior;
  } cell_t;

  typedef struct packed {
    logic          emit;
    logic [XW-1:0] ex;
    logic [XW-1:0] ey;
    logic          last;
  } meta_t;

  typedef struct packed {
    cell_t         entry;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    meta_t         meta;
  } job_t;

  typedef struct packed {
    logic               any;
    logic signed [15:0] vmax;
    logic signed [15:0] vmin;
    cell_t              centre;
  } colrec_t;

endpackage

### sv/wshf_queue.sv
module wshf_queue #(
  parameter int WIDTH,
  parameter int DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

### sv/wshf_front.sv
module wshf_front import wshf_pkg::*; #(
  parameter int MAX_WIDTH,
  parameter int MAX_HEIGHT,
  parameter int MAX_RADIUS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       push,
  input  item_t      item,
  output logic       full,
  output logic       job_push,
  output job_t       job,
  input  logic       job_full,
  output cfg_t       eff
);

  logic [XW-1:0]   cfg_w;
  logic [XW-1:0]   cfg_h;
  logic [RW-1:0]   cfg_r;
  logic [ACCW-1:0] acc;
  logic [XW-1:0]   x;
  logic [YW-1:0]   y;
  logic [XW-1:0]   ex;
  logic [XW-1:0]   ey;

  logic [XW-1:0]   w;
  logic [XW-1:0]   h;
  logic [XW-1:0]   half;
  logic [RW-1:0]   r_req;
  logic [RW-1:0]   r;
  logic [TOTW-1:0] total;
  logic [LAGW-1:0] lag;
  logic            accept;
  logic            is_cell;
  logic            start_new;
  logic            drop;
  logic [ACCW-1:0] p;
  logic [XW-1:0]   px;
  logic [YW-1:0]   py;
  logic [XW-1:0]   pex;
  logic [XW-1:0]   pey;
  logic            emit;
  logic            last;

  always_comb begin
    if (cfg_w == '0) begin
      w = XW'(1);
    end else if (int'(cfg_w) > MAX_WIDTH) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = cfg_w;
    end
    if (cfg_h == '0) begin
      h = XW'(1);
    end else if (int'(cfg_h) > MAX_HEIGHT) begin
      h = XW'(MAX_HEIGHT);
    end else begin
      h = cfg_h;
    end
    half  = ((w < h) ? w : h) >> 1;
    r_req = (int'(cfg_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : cfg_r;
    r     = (XW'(r_req) > half) ? RW'(half) : r_req;
    if (r == '0) begin
      r = RW'(1);
    end
    total = TOTW'(w) * TOTW'(h);
    lag   = LAGW'(r) * LAGW'(w) + LAGW'(r);
  end

  assign eff = '{width: w, height: h, radius: r};

  assign full      = job_full;
  assign accept    = push && !full;
  assign is_cell   = !item.action;
  assign start_new = is_cell && (acc >= ACCW'(total));
  assign drop      = !is_cell && (acc < ACCW'(total));
  assign p         = start_new ? '0 : acc;
  assign px        = start_new ? '0 : x;
  assign py        = start_new ? '0 : y;
  assign pex       = start_new ? '0 : ex;
  assign pey       = start_new ? '0 : ey;
  assign emit      = (p >= ACCW'(lag));
  assign last      = emit && (pex == w - XW'(1)) && (pey == h - XW'(1));
  assign job_push  = accept && !drop;

  always_comb begin
    job.entry.known = is_cell && item.known;
    job.entry.level = item.level;
    job.entry.prior = item.prior_step;
    job.x           = px;
    job.y           = py;
    job.meta.emit   = emit;
    job.meta.ex     = pex;
    job.meta.ey     = pey;
    job.meta.last   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= XW'(256);
      cfg_h <= XW'(256);
      cfg_r <= RW'(1);
      acc   <= '0;
      x     <= '0;
      y     <= '0;
      ex    <= '0;
      ey    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: begin
          cfg_w <= cfg_data;
          acc <= '0; x <= '0; y <= '0; ex <= '0; ey <= '0;
        end
        REG_GRID_HEIGHT: begin
          cfg_h <= cfg_data;
          acc <= '0; x <= '0; y <= '0; ex <= '0; ey <= '0;
        end
        REG_WINDOW_RADIUS: begin
          cfg_r <= cfg_data[RW-1:0];
          acc <= '0; x <= '0; y <= '0; ex <= '0; ey <= '0;
        end
        default: begin
        end
      endcase
    end else if (job_push) begin
      if (last) begin
        acc <= '0; x <= '0; y <= '0; ex <= '0; ey <= '0;
      end else begin
        acc <= p + ACCW'(1);
        if (px == w - XW'(1)) begin
          x <= '0;
          y <= py + YW'(1);
        end else begin
          x <= px + XW'(1);
          y <= py;
        end
        if (emit) begin
          if (pex == w - XW'(1)) begin
            ex <= '0;
            ey <= pey + XW'(1);
          end else begin
            ex <= pex + XW'(1);
            ey <= pey;
          end
        end else begin
          ex <= pex;
          ey <= pey;
        end
      end
    end
  end

endmodule

### sv/wshf_back.sv
module wshf_back import wshf_pkg::*; #(
  parameter int MAX_WIDTH,
  parameter int MAX_RADIUS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    eff,
  input  job_t    job,
  input  logic    job_empty,
  output logic    job_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  localparam int Taps = 2 * MAX_RADIUS + 1;
  localparam int SW   = $clog2(Taps);
  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CRW  = $clog2(OutDepth + 1);

  logic [CRW-1:0] credits;
  logic           take;
  logic           out_full;
  logic [SW-1:0]  slot;
  logic [SW-1:0]  slot_cur;
  logic [AW-1:0]  addr;

  cell_t lb [Taps][MAX_WIDTH];
  cell_t rd [Taps];

  logic          v1;
  job_t          job1;
  logic [SW-1:0] slot1;
  colrec_t       rec1;

  logic    v2;
  colrec_t rec2;
  meta_t   meta2;

  colrec_t chain [Taps];
  logic    v3;
  meta_t   meta3;
  colrec_t hrec3;

  logic    v4;
  colrec_t hrec4;
  meta_t   meta4;

  logic signed [16:0] d_up;
  logic signed [16:0] d_dn;
  logic [15:0]        step;
  result_t            res4;

  assign take    = !job_empty && !out_full && (credits < CRW'(OutDepth));
  assign job_pop = take;
  assign addr    = AW'(job.x);

  always_comb begin
    if (job.x != '0) begin
      slot_cur = slot;
    end else if (job.y == '0) begin
      slot_cur = '0;
    end else begin
      slot_cur = (slot == SW'(Taps - 1)) ? '0 : slot + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < Taps; s++) begin
      if (take && (slot_cur == SW'(s))) begin
        lb[s][addr] <= job.entry;
      end
      if (take) begin
        rd[s] <= lb[s][addr];
      end
    end
  end

  // Column pass: tap k holds the cell k rows above the incoming one.
  always_comb begin
    cell_t tap;
    int    si;
    rec1 = '0;
    for (int k = 0; k < Taps; k++) begin
      if (k == 0) begin
        tap = job1.entry;
      end else begin
        si = int'(slot1) - k;
        if (si < 0) begin
          si = si + Taps;
        end
        tap = rd[SW'(si)];
      end
      if (tap.known && (k <= 2 * int'(eff.radius)) && (k <= int'(job1.y))) begin
        if (!rec1.any || (tap.level > rec1.vmax)) begin
          rec1.vmax = tap.level;
        end
        if (!rec1.any || (tap.level < rec1.vmin)) begin
          rec1.vmin = tap.level;
        end
        rec1.any = 1'b1;
      end
      if (k == int'(eff.radius)) begin
        rec1.centre = tap;
      end
    end
  end

  // Row pass over the column results, clipped to the centre's row.
  always_comb begin
    int t;
    hrec3 = '0;
    for (int d = 0; d < Taps; d++) begin
      t = int'(meta3.ex) + int'(eff.radius) - d;
      if (chain[d].any && (d <= 2 * int'(eff.radius)) && (t >= 0)
          && (t < int'(eff.width))) begin
        if (!hrec3.any || (chain[d].vmax > hrec3.vmax)) begin
          hrec3.vmax = chain[d].vmax;
        end
        if (!hrec3.any || (chain[d].vmin < hrec3.vmin)) begin
          hrec3.vmin = chain[d].vmin;
        end
        hrec3.any = 1'b1;
      end
      if (d == int'(eff.radius)) begin
        hrec3.centre = chain[d].centre;
      end
    end
  end

  always_comb begin
    d_up = {hrec4.vmax[15], hrec4.vmax} - {hrec4.centre.level[15], hrec4.centre.level};
    d_dn = {hrec4.centre.level[15], hrec4.centre.level} - {hrec4.vmin[15], hrec4.vmin};
    step = hrec4.centre.prior;
    if (hrec4.any && (d_up[15:0] > step)) begin
      step = d_up[15:0];
    end
    if (hrec4.any && (d_dn[15:0] > step)) begin
      step = d_dn[15:0];
    end
    if (!hrec4.centre.known) begin
      step = '0;
    end
    res4.step_height   = step;
    res4.row           = 8'(meta4.ey);
    res4.column        = 8'(meta4.ex);
    res4.last_of_frame = meta4.last;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job1  <= job;
      slot1 <= slot_cur;
    end
    if (v1) begin
      rec2  <= rec1;
      meta2 <= job1.meta;
    end
    if (v2) begin
      chain[0] <= rec2;
      for (int i = 1; i < Taps; i++) begin
        chain[i] <= chain[i-1];
      end
      meta3 <= meta2;
    end
    if (v3) begin
      hrec4 <= hrec3;
      meta4 <= meta3;
    end
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      slot    <= '0;
      credits <= '0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2 && meta2.emit;
      v4 <= v3;
      if (take) begin
        slot <= slot_cur;
      end
      if ((take && job.meta.emit) && !(pop && !empty)) begin
        credits <= credits + CRW'(1);
      end else if (!(take && job.meta.emit) && (pop && !empty)) begin
        credits <= credits - CRW'(1);
      end
    end
  end

  wshf_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(OutDepth)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (v4),
    .wdata(res4),
    .full (out_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

endmodule

### sv/window_step_height_filter_core.sv
// Channel    Direction  Handshake              Payload
// item       in         push / full            item_t (action, known, level, prior_step)
// result     out        pop / empty            result_t (step_height, row, column, last)
// config     in         cfg_write              cfg_index, cfg_data
//
// One request is taken per cycle while full is low; each job flows through a
// pipeline of line-buffer read, column pass, row chain, row pass and step.
// A result appears R*W+R requests after its cell.
// Reset is synchronous and clears all counters and queues; the line buffers hold
// no reset and are only read where this frame has written them.
// Result-queue credits stall the back end; the mid queue absorbs that, then full rises.
module window_step_height_filter_core import wshf_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       push,
  input  item_t      item,
  output logic       full,
  input  logic       pop,
  output result_t    result,
  output logic       empty
);

  logic job_push;
  job_t job_in;
  logic job_full;
  logic job_pop;
  job_t job_out;
  logic job_empty;
  cfg_t eff;

  wshf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .push     (push),
    .item     (item),
    .full     (full),
    .job_push (job_push),
    .job      (job_in),
    .job_full (job_full),
    .eff      (eff)
  );

  wshf_queue #(
    .WIDTH($bits(job_t)),
    .DEPTH(MidDepth)
  ) u_mid_queue (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .wdata(job_in),
    .full (job_full),
    .pop  (job_pop),
    .rdata(job_out),
    .empty(job_empty)
  );

  wshf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .eff      (eff),
    .job      (job_out),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

### sv/wshf_checker.sv
module wshf_checker import wshf_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    pop,
  input logic    empty,
  input result_t result
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_ready_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result vanished");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("waiting result changed");

endmodule

bind window_step_height_filter_core wshf_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .pop   (pop),
  .empty (empty),
  .result(result)
);
